FILE: rtl/rotation_matrix_to_zyx_euler_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ZYX Euler angle block
// Shared macros used by the checker to write its concurrent assertions.
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_ZYX_EULER_TOP_MACROS_SVH
`define ROTATION_MATRIX_TO_ZYX_EULER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RMZYX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmzyx assertion failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define RMZYX_ASSERT_DLY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##dly (cons)) \
    else $error("rmzyx assertion failed");

`endif

FILE: rtl/rmzyx_pkg.sv
// ---------------------------------------------------------------------------
// ZYX Euler angle package
// Types, constants and helper functions shared by the CORDIC pipeline.
// ---------------------------------------------------------------------------
package rmzyx_pkg;

  localparam int VW = 36;
  localparam int ZW = 20;
  localparam int TABLE_LEN = 24;
  localparam logic signed [ZW-1:0] HALF_PI_Z = 20'sd102944;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic signed [17:0] YAW_LIMIT = 18'sd25736;
  localparam logic signed [17:0] PITCH_LIMIT = 18'sd12868;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [ZW-1:0] z;
    logic zero;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0] ax;
    logic signed [VW-1:0] ay;
    logic signed [VW-1:0] bx;
    logic signed [VW-1:0] by;
  } sh_t;

  function automatic logic signed [VW-1:0] widen(input logic signed [15:0] v);
    return {{(VW-32){v[15]}}, v, 16'b0};
  endfunction

  function automatic logic signed [ZW-1:0] atan_step(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 20'sd51472;
      1: r = 20'sd30386;
      2: r = 20'sd16055;
      3: r = 20'sd8150;
      4: r = 20'sd4091;
      5: r = 20'sd2047;
      6: r = 20'sd1024;
      7: r = 20'sd512;
      8: r = 20'sd256;
      9: r = 20'sd128;
      10: r = 20'sd64;
      11: r = 20'sd32;
      12: r = 20'sd16;
      13: r = 20'sd8;
      14: r = 20'sd4;
      15: r = 20'sd2;
      16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [17:0] to_q213(input logic signed [ZW-1:0] z,
                                                  input logic signed [17:0] lim);
    logic signed [ZW:0] s;
    logic signed [17:0] a;
    s = {z[ZW-1], z} + 21'sd4;
    a = s[ZW:3];
    if (a > lim) a = lim;
    if (a < -lim) a = -lim;
    return a;
  endfunction

endpackage

FILE: rtl/rotation_matrix_to_zyx_euler_top.sv
// ---------------------------------------------------------------------------
// Rotation matrix to ZYX Euler angles
// Fully pipelined CORDIC that turns seven rotation matrix entries into
// yaw, pitch and roll.
// ---------------------------------------------------------------------------
// The block takes a new matrix in every clock cycle outside reset and
// returns its angles in the same order, one transaction out for each
// transaction in. The pipeline runs the yaw chain of CORDIC cells and
// then the parallel pitch and roll chains, one cell per micro-rotation,
// with a quarter-turn stage in front of each chain, two gain correction
// stages between them and one output register. busy is high only during
// reset. done marks each result for a single cycle.
module rotation_matrix_to_zyx_euler_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] col0_x,
  input  logic signed [15:0] col0_y,
  input  logic signed [15:0] col0_z,
  input  logic signed [15:0] col1_x,
  input  logic signed [15:0] col1_y,
  input  logic signed [15:0] col2_x,
  input  logic signed [15:0] col2_y,
  output logic done,
  output logic signed [15:0] yaw_angle,
  output logic signed [14:0] pitch_angle,
  output logic signed [15:0] roll_angle
);
  import rmzyx_pkg::*;

  localparam int N = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
  localparam int LAT = 2 * N + 5;

  logic accept;
  logic [LAT-1:0] vld;

  vec_t yaw_vec [N+1];
  sh_t yaw_sh [N+1];
  logic signed [15:0] z_line [N+1];
  logic signed [ZW-1:0] yaw_z_line [N+3];
  logic signed [VW-1:0] pitch_x, pitch_y, roll_x, roll_y;
  vec_t pit_vec [N+1];
  sh_t pit_sh [N+1];
  vec_t rol_vec [N+1];
  sh_t rol_sh [N+1];
  sh_t sh_in;

  assign busy = rst;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], accept};
    end
  end
  assign done = vld[LAT-1];

  always_comb begin
    sh_in.ax = widen(col1_x);
    sh_in.ay = widen(col1_y);
    sh_in.bx = widen(col2_x);
    sh_in.by = widen(col2_y);
  end

  rmzyx_prerot u_yaw_pre (
    .clk(clk), .x(widen(col0_x)), .y(widen(col0_y)), .sh_in(sh_in),
    .vec_out(yaw_vec[0]), .sh_out(yaw_sh[0])
  );

  always_ff @(posedge clk) begin
    z_line[0] <= col0_z;
    for (int k = 1; k <= N; k++) begin
      z_line[k] <= z_line[k-1];
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_yaw
    rmzyx_cell #(.STEP(i)) u_cell (
      .clk(clk), .vec_in(yaw_vec[i]), .sh_in(yaw_sh[i]),
      .vec_out(yaw_vec[i+1]), .sh_out(yaw_sh[i+1])
    );
  end

  rmzyx_gain u_gain (
    .clk(clk), .mag_in(yaw_vec[N].x), .col0_z_in(z_line[N]), .sh_in(yaw_sh[N]),
    .pitch_x(pitch_x), .pitch_y(pitch_y), .roll_x(roll_x), .roll_y(roll_y)
  );

  always_ff @(posedge clk) begin
    yaw_z_line[0] <= yaw_vec[N].z;
    for (int k = 1; k < N + 3; k++) begin
      yaw_z_line[k] <= yaw_z_line[k-1];
    end
  end

  rmzyx_prerot u_pit_pre (
    .clk(clk), .x(pitch_x), .y(pitch_y), .sh_in('0),
    .vec_out(pit_vec[0]), .sh_out(pit_sh[0])
  );

  rmzyx_prerot u_rol_pre (
    .clk(clk), .x(roll_x), .y(roll_y), .sh_in('0),
    .vec_out(rol_vec[0]), .sh_out(rol_sh[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_pr
    rmzyx_cell #(.STEP(i)) u_pit (
      .clk(clk), .vec_in(pit_vec[i]), .sh_in(pit_sh[i]),
      .vec_out(pit_vec[i+1]), .sh_out(pit_sh[i+1])
    );
    rmzyx_cell #(.STEP(i)) u_rol (
      .clk(clk), .vec_in(rol_vec[i]), .sh_in(rol_sh[i]),
      .vec_out(rol_vec[i+1]), .sh_out(rol_sh[i+1])
    );
  end

  always_ff @(posedge clk) begin
    yaw_angle <= 16'(to_q213(yaw_z_line[N+2], YAW_LIMIT));
    pitch_angle <= 15'(to_q213(pit_vec[N].z, PITCH_LIMIT));
    roll_angle <= 16'(to_q213(rol_vec[N].z, YAW_LIMIT));
  end

endmodule

FILE: rtl/rmzyx_prerot.sv
// ---------------------------------------------------------------------------
// CORDIC pre-rotation stage
// Folds a vector into the right half plane by a quarter turn and flags
// the zero vector; shadow vectors receive the same quarter turn.
// ---------------------------------------------------------------------------
module rmzyx_prerot (
  input  logic clk,
  input  logic signed [rmzyx_pkg::VW-1:0] x,
  input  logic signed [rmzyx_pkg::VW-1:0] y,
  input  rmzyx_pkg::sh_t sh_in,
  output rmzyx_pkg::vec_t vec_out,
  output rmzyx_pkg::sh_t sh_out
);
  import rmzyx_pkg::*;

  vec_t vec_next;
  sh_t sh_next;

  always_comb begin
    vec_next.x = x;
    vec_next.y = y;
    vec_next.z = '0;
    vec_next.zero = (x == '0) && (y == '0);
    sh_next = sh_in;
    if (x[VW-1]) begin
      if (!y[VW-1]) begin
        vec_next.x = y;
        vec_next.y = -x;
        vec_next.z = HALF_PI_Z;
        sh_next.ax = sh_in.ay;
        sh_next.ay = -sh_in.ax;
        sh_next.bx = sh_in.by;
        sh_next.by = -sh_in.bx;
      end else begin
        vec_next.x = -y;
        vec_next.y = x;
        vec_next.z = -HALF_PI_Z;
        sh_next.ax = -sh_in.ay;
        sh_next.ay = sh_in.ax;
        sh_next.bx = -sh_in.by;
        sh_next.by = sh_in.bx;
      end
    end
  end

  always_ff @(posedge clk) begin
    vec_out <= vec_next;
    sh_out <= sh_next;
  end

endmodule

FILE: rtl/rmzyx_cell.sv
// ---------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation with a fixed shift; shadow vectors follow the same
// direction. A zero vector passes through unchanged.
// ---------------------------------------------------------------------------
module rmzyx_cell #(
  parameter int STEP = 0
) (
  input  logic clk,
  input  rmzyx_pkg::vec_t vec_in,
  input  rmzyx_pkg::sh_t sh_in,
  output rmzyx_pkg::vec_t vec_out,
  output rmzyx_pkg::sh_t sh_out
);
  import rmzyx_pkg::*;

  vec_t vec_next;
  sh_t sh_next;
  logic cw;

  always_comb begin
    cw = !vec_in.y[VW-1];
    vec_next = vec_in;
    sh_next = sh_in;
    if (!vec_in.zero) begin
      if (cw) begin
        vec_next.x = vec_in.x + (vec_in.y >>> STEP);
        vec_next.y = vec_in.y - (vec_in.x >>> STEP);
        vec_next.z = vec_in.z + atan_step(STEP);
        sh_next.ax = sh_in.ax + (sh_in.ay >>> STEP);
        sh_next.ay = sh_in.ay - (sh_in.ax >>> STEP);
        sh_next.bx = sh_in.bx + (sh_in.by >>> STEP);
        sh_next.by = sh_in.by - (sh_in.bx >>> STEP);
      end else begin
        vec_next.x = vec_in.x - (vec_in.y >>> STEP);
        vec_next.y = vec_in.y + (vec_in.x >>> STEP);
        vec_next.z = vec_in.z - atan_step(STEP);
        sh_next.ax = sh_in.ax - (sh_in.ay >>> STEP);
        sh_next.ay = sh_in.ay + (sh_in.ax >>> STEP);
        sh_next.bx = sh_in.bx - (sh_in.by >>> STEP);
        sh_next.by = sh_in.by + (sh_in.bx >>> STEP);
      end
    end
  end

  always_ff @(posedge clk) begin
    vec_out <= vec_next;
    sh_out <= sh_next;
  end

endmodule

FILE: rtl/rmzyx_gain.sv
// ---------------------------------------------------------------------------
// Gain correction stage
// Removes the CORDIC gain from the first column's length over two stages
// and forms the vectors for the pitch and roll angles.
// ---------------------------------------------------------------------------
module rmzyx_gain (
  input  logic clk,
  input  logic signed [rmzyx_pkg::VW-1:0] mag_in,
  input  logic signed [15:0] col0_z_in,
  input  rmzyx_pkg::sh_t sh_in,
  output logic signed [rmzyx_pkg::VW-1:0] pitch_x,
  output logic signed [rmzyx_pkg::VW-1:0] pitch_y,
  output logic signed [rmzyx_pkg::VW-1:0] roll_x,
  output logic signed [rmzyx_pkg::VW-1:0] roll_y
);
  import rmzyx_pkg::*;

  logic [46:0] p_lo;
  logic [46:0] p_hi;
  logic signed [15:0] col0_z_a;
  logic signed [VW-1:0] ay_a;
  logic signed [VW-1:0] by_a;
  logic [VW+29:0] sum;

  always_ff @(posedge clk) begin
    p_lo <= 47'(mag_in[16:0]) * 47'(INV_GAIN_Q30);
    p_hi <= 47'(mag_in[33:17]) * 47'(INV_GAIN_Q30);
    col0_z_a <= col0_z_in;
    ay_a <= sh_in.ay;
    by_a <= sh_in.by;
  end

  always_comb begin
    sum = ((VW+30)'(p_hi) << 17) + (VW+30)'(p_lo) + (VW+30)'(1 << 29);
  end

  always_ff @(posedge clk) begin
    pitch_x <= signed'(sum[VW+29:30]);
    pitch_y <= -widen(col0_z_a);
    roll_x <= ay_a;
    roll_y <= -by_a;
  end

endmodule

FILE: rtl/rmzyx_checker.sv
// ---------------------------------------------------------------------------
// ZYX Euler angle port checker
// Watches the top level's ports for latency and output range.
// ---------------------------------------------------------------------------
`include "rotation_matrix_to_zyx_euler_top_macros.svh"

module rmzyx_checker #(
  parameter int CORDIC_STEPS = 16
) (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [15:0] yaw_angle,
  input logic signed [14:0] pitch_angle,
  input logic signed [15:0] roll_angle
);
  localparam int N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int LAT = 2 * N + 5;

  `RMZYX_ASSERT_DLY(a_latency, start && !busy, LAT, done)
  `RMZYX_ASSERT_IMP(a_yaw_range, done, yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736)
  `RMZYX_ASSERT_IMP(a_pitch_range, done,
                    pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868)
  `RMZYX_ASSERT_IMP(a_roll_range, done, roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736)

endmodule

bind rotation_matrix_to_zyx_euler_top rmzyx_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .yaw_angle(yaw_angle), .pitch_angle(pitch_angle), .roll_angle(roll_angle)
);
